// ===== hdl/cic_pkg.sv =====
// cic_pkg: shared constants for the control input conditioner
// no dependencies; used by the channel interfaces and the top level

package cic_pkg;

  localparam int VALUE_W    = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int KIND_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_INPUT_KIND  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LOW   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_LOW  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_HIGH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_HIGH  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WINDOW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STICK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [VALUE_W-1:0] VALUE_OFF  = 8'd0;
  localparam logic [VALUE_W-1:0] VALUE_ON   = 8'd1;
  localparam logic [VALUE_W-1:0] LOWER_BASE = 8'd0;
  localparam logic [VALUE_W-1:0] DEAD_VALUE = 8'd128;
  localparam logic [VALUE_W-1:0] VALUE_MAX  = 8'd255;

  localparam int SEG_GAIN_SHIFT = 7;

  localparam int CENTER_LOW_RST  = 500;
  localparam int CENTER_HIGH_RST = 523;

endpackage

// ===== hdl/cic_intf.sv =====
// cic_intf: valid/ready channel interfaces for sample, result and config requests
// depends on cic_pkg

interface cic_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic                   button_level;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output button_level, output adc_sample, input ready);
  modport sink   (input valid, input button_level, input adc_sample, output ready);
endinterface

interface cic_out_if;
  logic                         valid;
  logic                         ready;
  logic [cic_pkg::VALUE_W-1:0] value;
  logic                         changed;

  modport source (output valid, output value, output changed, input ready);
  modport sink   (input valid, input value, input changed, output ready);
endinterface

interface cic_cfg_if #(parameter int SAMPLE_BITS = 10);
  logic                            valid;
  logic                            ready;
  logic [cic_pkg::CFG_ADDR_W-1:0] addr;
  logic [SAMPLE_BITS-1:0]          data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hdl/control_input_conditioner.sv =====
// control_input_conditioner: button, window and stick conditioning of one input
// depends on cic_pkg and the channel interfaces in cic_intf
//
// One request gives one result. Button, window and unused-kind samples and stick
// readings in the dead zone or on a zero-width segment pass through the setup and
// done states; other stick readings go through one shared restoring divider that
// yields one quotient bit a cycle for a quotient of SAMPLE_BITS+7 bits, then through
// a fix state for sign and saturation before done. A new request is taken only once
// the previous result has moved into the output register. Config writes are always
// ready and are meant for idle periods only.

module control_input_conditioner #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cic_in_if.sink    sample_i,
  cic_out_if.source result_o,
  cic_cfg_if.sink   cfg_i
);

  localparam int SB    = SAMPLE_BITS;
  localparam int QW    = SB + cic_pkg::SEG_GAIN_SHIFT;
  localparam int CNT_W = $clog2(QW);
  localparam int VW    = cic_pkg::VALUE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_FIX   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [cic_pkg::KIND_W-1:0] kind_q;
  logic [SB-1:0] range_low_q, center_low_q, center_high_q, range_high_q;
  logic [VW-1:0] cur_q, cur_d;

  logic          level_q;
  logic [SB-1:0] sample_q;

  logic [VW-1:0] res_q, res_d;
  logic          chg_q, chg_d;
  logic          neg_q, neg_d;
  logic [VW-1:0] base_q, base_d;
  logic [SB-1:0] den_q, den_d;
  logic [SB-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_value_q;
  logic          out_chg_q;
  logic          out_load;

  // segment selection and operand setup
  logic          lower_seg, dead_zone, in_window;
  logic [SB-1:0] seg_a, seg_b;
  logic [SB:0]   diff, span;
  logic [SB-1:0] diff_mag, span_mag;
  logic [QW-1:0] num_mag;
  logic [VW-1:0] btn_value;

  // divider step
  logic [SB:0]   trial;
  logic          trial_ge;

  // sign fix and saturation
  logic [QW:0]   pos_sum;
  logic [VW-1:0] fix_value;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;

  assign result_o.valid   = out_valid_q;
  assign result_o.value   = out_value_q;
  assign result_o.changed = out_chg_q;

  always_comb begin
    lower_seg = (sample_q <= center_low_q);
    dead_zone = !lower_seg && (sample_q <= center_high_q);
    in_window = (sample_q >= range_low_q) && (sample_q <= range_high_q);
    seg_a     = lower_seg ? range_low_q : center_high_q;
    seg_b     = lower_seg ? center_low_q : range_high_q;
    diff      = {1'b0, sample_q} - {1'b0, seg_a};
    span      = {1'b0, seg_b} - {1'b0, seg_a};
    diff_mag  = diff[SB] ? SB'(-diff) : diff[SB-1:0];
    span_mag  = span[SB] ? SB'(-span) : span[SB-1:0];
    num_mag   = (QW'(diff_mag) << cic_pkg::SEG_GAIN_SHIFT) - QW'(diff_mag);
    btn_value = level_q ? cic_pkg::VALUE_OFF : cic_pkg::VALUE_ON;
  end

  always_comb begin
    trial    = {rem_q, quo_q[QW-1]};
    trial_ge = (trial >= {1'b0, den_q});
  end

  always_comb begin
    pos_sum = {1'b0, quo_q} + (QW+1)'(base_q);
    if (neg_q) begin
      fix_value = (quo_q > QW'(base_q)) ? cic_pkg::VALUE_OFF : base_q - quo_q[VW-1:0];
    end else begin
      fix_value = (pos_sum > (QW+1)'(cic_pkg::VALUE_MAX)) ? cic_pkg::VALUE_MAX
                                                          : pos_sum[VW-1:0];
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    chg_d       = chg_q;
    neg_d       = neg_q;
    base_d      = base_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        chg_d   = 1'b0;
        res_d   = cur_q;
        state_d = ST_DONE;
        unique case (kind_q)
          cic_pkg::KIND_BUTTON: begin
            res_d = btn_value;
            chg_d = (btn_value != cur_q);
          end
          cic_pkg::KIND_WINDOW: begin
            res_d = in_window ? cic_pkg::VALUE_ON : cic_pkg::VALUE_OFF;
            chg_d = (res_d != cur_q);
          end
          cic_pkg::KIND_STICK: begin
            base_d = lower_seg ? cic_pkg::LOWER_BASE : cic_pkg::DEAD_VALUE;
            if (dead_zone) begin
              res_d = cic_pkg::DEAD_VALUE;
            end else if (span == '0) begin
              res_d = base_d;
            end else begin
              neg_d   = diff[SB] ^ span[SB];
              den_d   = span_mag;
              rem_d   = '0;
              quo_d   = num_mag;
              cnt_d   = CNT_W'(QW - 1);
              state_d = ST_DIV;
            end
          end
          cic_pkg::KIND_UNUSED: begin
            res_d = cur_q;
          end
          default: begin
            res_d = cur_q;
          end
        endcase
      end
      ST_DIV: begin
        rem_d = trial_ge ? SB'(trial - {1'b0, den_q}) : trial[SB-1:0];
        quo_d = {quo_q[QW-2:0], trial_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        res_d   = fix_value;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          cur_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      cur_q         <= '0;
      kind_q        <= cic_pkg::KIND_BUTTON;
      range_low_q   <= '0;
      center_low_q  <= SB'(cic_pkg::CENTER_LOW_RST);
      center_high_q <= SB'(cic_pkg::CENTER_HIGH_RST);
      range_high_q  <= '1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.addr)
          cic_pkg::REG_INPUT_KIND:  kind_q        <= cfg_i.data[cic_pkg::KIND_W-1:0];
          cic_pkg::REG_RANGE_LOW:   range_low_q   <= cfg_i.data;
          cic_pkg::REG_CENTER_LOW:  center_low_q  <= cfg_i.data;
          cic_pkg::REG_CENTER_HIGH: center_high_q <= cfg_i.data;
          cic_pkg::REG_RANGE_HIGH:  range_high_q  <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      level_q  <= sample_i.button_level;
      sample_q <= sample_i.adc_sample;
    end
    res_q  <= res_d;
    chg_q  <= chg_d;
    neg_q  <= neg_d;
    base_q <= base_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    if (out_load) begin
      out_value_q <= res_q;
      out_chg_q   <= chg_q;
    end
  end

endmodule

// ===== dv/control_input_conditioner_test.sv =====
// control_input_conditioner_test: self-checking bench for button, window and stick conditioning
// drives sample and config requests through the cic_intf channels, predicts each result
// depends on cic_pkg, cic_intf and the control_input_conditioner top level

module control_input_conditioner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cic_pkg::*;

  localparam int SAMPLE_W = 10;
  localparam int LATENCY  = SAMPLE_W + 10;
  localparam int SMP_MAX  = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               changed;
  } cond_result_t;

  logic clk;
  logic rst_n;

  cic_in_if  #(.SAMPLE_BITS(SAMPLE_W)) sample_if ();
  cic_out_if                           result_if ();
  cic_cfg_if #(.SAMPLE_BITS(SAMPLE_W)) cfg_if ();

  control_input_conditioner #(
    .SAMPLE_BITS(SAMPLE_W)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(sample_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  logic [KIND_W-1:0]   cur_kind;
  logic [SAMPLE_W-1:0] lo_edge;
  logic [SAMPLE_W-1:0] mid_lo;
  logic [SAMPLE_W-1:0] mid_hi;
  logic [SAMPLE_W-1:0] hi_edge;
  logic [VALUE_W-1:0]  stored_value;

  cond_result_t pending_results[$];
  int           mismatch_count;
  int           hold_cycles;
  bit           src_idle_en;
  bit           sink_idle_en;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint seg_line(longint x, longint a, longint b, longint base);
    longint span;
    span = b - a;
    if (span == 0) return base;
    return ((x - a) * 127) / span + base;
  endfunction

  function automatic cond_result_t condition_sample(logic lvl, logic [SAMPLE_W-1:0] smp);
    cond_result_t       res;
    logic [VALUE_W-1:0] next_value;
    longint             pos;
    longint             top;
    top = longint'(VALUE_MAX);
    res.changed = 1'b0;
    case (cur_kind)
      KIND_BUTTON, KIND_WINDOW: begin
        if (cur_kind == KIND_BUTTON) begin
          next_value = lvl ? VALUE_OFF : VALUE_ON;
        end else begin
          next_value = (smp >= lo_edge && smp <= hi_edge) ? VALUE_ON : VALUE_OFF;
        end
        if (next_value != stored_value) begin
          stored_value = next_value;
          res.changed  = 1'b1;
        end
      end
      KIND_STICK: begin
        if (smp <= mid_lo) begin
          pos = seg_line(longint'(smp), longint'(lo_edge), longint'(mid_lo),
                         longint'(LOWER_BASE));
        end else if (smp <= mid_hi) begin
          pos = longint'(DEAD_VALUE);
        end else begin
          pos = seg_line(longint'(smp), longint'(mid_hi), longint'(hi_edge),
                         longint'(DEAD_VALUE));
        end
        if (pos > top) pos = top;
        if (pos < 0) pos = 0;
        stored_value = pos[VALUE_W-1:0];
      end
      default: begin
      end
    endcase
    res.value = stored_value;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cond_result_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result value %0d changed %0d with nothing pending",
                                  result_if.value, result_if.changed));
      end else begin
        want = pending_results.pop_front();
        if (result_if.value !== want.value) begin
          report_mismatch($sformatf("value got %0d want %0d", result_if.value, want.value));
        end
        if (result_if.changed !== want.changed) begin
          report_mismatch($sformatf("changed got %0d want %0d",
                                    result_if.changed, want.changed));
        end
      end
    end
  end

  // result side: short random stalls, with a long hold taking priority whenever one is set
  initial begin
    int stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_if.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        result_if.ready = 1'b0;
        stall_left--;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        result_if.ready = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        result_if.ready = 1'b1;
      end
    end
  end

  task automatic send_sample(input logic lvl, input logic [SAMPLE_W-1:0] smp);
    int gap;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      sample_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.valid        = 1'b1;
    sample_if.button_level = lvl;
    sample_if.adc_sample   = smp;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    pending_results.push_back(condition_sample(lvl, smp));
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.addr  = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_INPUT_KIND:  cur_kind = val[KIND_W-1:0];
      REG_RANGE_LOW:   lo_edge  = val;
      REG_CENTER_LOW:  mid_lo   = val;
      REG_CENTER_HIGH: mid_hi   = val;
      REG_RANGE_HIGH:  hi_edge  = val;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [SAMPLE_W-1:0] kind_word,
                            input int rl, input int cl, input int ch, input int rh);
    write_reg(REG_INPUT_KIND, kind_word);
    write_reg(REG_RANGE_LOW, SAMPLE_W'(rl));
    write_reg(REG_CENTER_LOW, SAMPLE_W'(cl));
    write_reg(REG_CENTER_HIGH, SAMPLE_W'(ch));
    write_reg(REG_RANGE_HIGH, SAMPLE_W'(rh));
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // wait until every request has its result and the block is quiet
  task automatic settle();
    @(negedge clk);
    sample_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = int'(lo_edge);
          1: v = int'(mid_lo);
          2: v = int'(mid_hi);
          default: v = int'(hi_edge);
        endcase
        v = v + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > SMP_MAX) v = SMP_MAX;
      end
      1: v = $urandom_range(0, 1) ? SMP_MAX : 0;
      default: v = $urandom_range(0, SMP_MAX);
    endcase
    return SAMPLE_W'(v);
  endfunction

  task automatic test_button_from_reset();
    send_sample(1'b1, '0);
    send_sample(1'b0, SAMPLE_W'(SMP_MAX));
    send_sample(1'b0, '0);
    send_sample(1'b1, SAMPLE_W'(SMP_MAX));
  endtask

  task automatic test_window();
    settle();
    set_config(SAMPLE_W'(KIND_WINDOW), 100, 300, 700, 900);
    send_sample(1'b0, 10'd99);
    send_sample(1'b1, 10'd100);
    send_sample(1'b0, 10'd900);
    send_sample(1'b1, 10'd901);
  endtask

  task automatic test_stick_segments();
    settle();
    set_config(SAMPLE_W'(KIND_STICK), 0, CENTER_LOW_RST, CENTER_HIGH_RST, SMP_MAX);
    send_sample(1'b1, 10'd0);
    send_sample(1'b0, SAMPLE_W'(SMP_MAX));
    send_sample(1'b1, 10'd500);
    send_sample(1'b0, 10'd501);
    send_sample(1'b1, 10'd523);
    send_sample(1'b0, 10'd524);
  endtask

  task automatic test_stick_corner_cases();
    // zero-width lower and upper segments
    settle();
    set_config(SAMPLE_W'(KIND_STICK), 500, 500, 523, 523);
    send_sample(1'b1, 10'd500);
    send_sample(1'b0, 10'd600);
    // readings outside the segments saturate
    settle();
    set_config(SAMPLE_W'(KIND_STICK), 600, 700, 800, 900);
    send_sample(1'b1, 10'd100);
    send_sample(1'b0, SAMPLE_W'(SMP_MAX));
    // reversed segment ends
    settle();
    set_config(SAMPLE_W'(KIND_STICK), 400, 100, 1000, 900);
    send_sample(1'b1, 10'd50);
    send_sample(1'b0, 10'd1010);
  endtask

  task automatic test_mode_switch();
    settle();
    set_config(SAMPLE_W'(KIND_STICK), 0, 500, 523, SMP_MAX);
    send_sample(1'b1, SAMPLE_W'(SMP_MAX));
    settle();
    set_config(SAMPLE_W'(KIND_UNUSED), 0, 500, 523, SMP_MAX);
    send_sample(1'b0, 10'd0);
    settle();
    set_config(SAMPLE_W'(KIND_BUTTON), 0, 500, 523, SMP_MAX);
    send_sample(1'b0, 10'd300);
  endtask

  task automatic test_backpressure();
    settle();
    set_config(SAMPLE_W'(KIND_STICK), 0, CENTER_LOW_RST, CENTER_HIGH_RST, SMP_MAX);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    @(posedge clk);
    hold_cycles = 200;
    repeat (30) send_sample(1'($urandom_range(0, 1)), pick_sample());
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_phases(input int phases, input int per_phase, input bit idle_on);
    int                  bounds[$];
    int                  shape;
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] kind_word;
    for (int p = 0; p < phases; p++) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1:    kind = KIND_BUTTON;
        2, 3, 4: kind = KIND_WINDOW;
        9:       kind = KIND_UNUSED;
        default: kind = KIND_STICK;
      endcase
      kind_word = {(SAMPLE_W-KIND_W)'($urandom), kind};
      shape = $urandom_range(0, 3);
      bounds = {};
      repeat (4) begin
        case (shape)
          1: begin
            case ($urandom_range(0, 2))
              0: bounds.push_back(0);
              1: bounds.push_back(SMP_MAX);
              default: bounds.push_back($urandom_range(0, SMP_MAX));
            endcase
          end
          2: bounds.push_back(480 + $urandom_range(0, 60));
          default: bounds.push_back($urandom_range(0, SMP_MAX));
        endcase
      end
      if (shape == 3) begin
        bounds[1] = bounds[0];
        bounds[3] = bounds[2];
      end
      if ($urandom_range(0, 3) != 0) bounds.sort();
      set_config(kind_word, bounds[0], bounds[1], bounds[2], bounds[3]);
      src_idle_en  = idle_on && ($urandom_range(0, 2) != 0);
      sink_idle_en = idle_on && ($urandom_range(0, 2) != 0);
      repeat (per_phase) send_sample(1'($urandom_range(0, 1)), pick_sample());
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    sample_if.valid        = 1'b0;
    sample_if.button_level = 1'b1;
    sample_if.adc_sample   = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.addr            = REG_INPUT_KIND;
    cfg_if.data            = '0;
    cur_kind               = KIND_BUTTON;
    lo_edge                = '0;
    mid_lo                 = SAMPLE_W'(CENTER_LOW_RST);
    mid_hi                 = SAMPLE_W'(CENTER_HIGH_RST);
    hi_edge                = SAMPLE_W'(SMP_MAX);
    stored_value           = VALUE_OFF;
    mismatch_count         = 0;
    hold_cycles            = 0;
    src_idle_en            = 1'b1;
    sink_idle_en           = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_button_from_reset();
    test_window();
    test_stick_segments();
    test_stick_corner_cases();
    test_mode_switch();
    test_backpressure();
    test_random_phases(9, 50, 1'b1);
    test_random_phases(1, 40, 1'b0);

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
